>>> src/image_contrast_stretch_macros.svh
// ----------------------------------------------------------------------------
// image_contrast_stretch_macros.svh
// Assertion macros for the contrast stretch block.
// ----------------------------------------------------------------------------
`ifndef IMAGE_CONTRAST_STRETCH_MACROS_SVH
`define IMAGE_CONTRAST_STRETCH_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ICS_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ics assertion failed");

`define ICS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ics implication failed");

`else

`define ICS_ASSERT(lbl, clk, rst_n, cond)

`define ICS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/ics_pkg.sv
// ----------------------------------------------------------------------------
// ics_pkg
// Shared types and constants of the contrast stretch block.
// ----------------------------------------------------------------------------
`default_nettype none

package ics_pkg;

    localparam int PIX_W   = 8;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_FULL = 2'd1,
        CLS_DIV  = 2'd2
    } t_cls;

    typedef struct packed {
        t_cls             cls;
        logic [PIX_W-1:0] diff;
        logic [PIX_W-1:0] span;
        logic             last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

>>> src/image_contrast_stretch.sv
// ----------------------------------------------------------------------------
// image_contrast_stretch
// Two-pass min-max contrast stretch of 8-bit grey pixels.
//
//   channel   direction  handshake          word
//   input     in         i_valid / o_stall  i_kind, i_pixel, i_last
//   output    out        o_valid / i_stall  o_stretched, o_final_res
//
// Measuring words are taken one per cycle while the queue has room.
// The back resolves a normalizing word directly when it saturates or the
// image is flat, otherwise by a load and 8 restoring divider steps.
// The 2-entry queue lets the front keep accepting while the back divides.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_contrast_stretch_macros.svh"

module image_contrast_stretch
    import ics_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_kind,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic             i_last,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [PIX_W-1:0]      o_stretched,
    output logic                  o_final_res
);

    t_qstat qstat;
    t_entry push_entry;
    t_entry head;
    logic   q_push;
    logic   q_pop;

    ics_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_pixel (i_pixel),
        .i_last  (i_last),
        .i_qstat (qstat),
        .o_stall (o_stall),
        .o_push  (q_push),
        .o_entry (push_entry)
    );

    ics_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    ics_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .i_stall     (i_stall),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_stretched (o_stretched),
        .o_final_res (o_final_res)
    );

    `ICS_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, q_push, !qstat.full)
    `ICS_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, q_pop, !qstat.empty)
    `ICS_ASSERT_IMPL(a_measure_no_push, i_clk, i_rst_n, i_valid && !o_stall && !i_kind, !q_push)

endmodule

`default_nettype wire

>>> src/ics_front.sv
// ----------------------------------------------------------------------------
// ics_front
// Accepts words, tracks min/max, classifies normalizing words for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ics_front
    import ics_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_kind,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic             i_last,
    input  wire t_qstat           i_qstat,
    output logic                  o_stall,
    output logic                  o_push,
    output t_entry                o_entry
);

    logic [PIX_W-1:0] r_low,  n_low;
    logic [PIX_W-1:0] r_high, n_high;
    logic             r_awaiting, n_awaiting;
    logic             accept;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;
    assign o_push  = accept && i_kind;

    always_comb begin
        o_entry.diff = i_pixel - r_low;
        o_entry.span = r_high - r_low;
        o_entry.last = i_last;
        if (r_high <= r_low) begin
            o_entry.cls = CLS_ZERO;
        end else if (i_pixel <= r_low) begin
            o_entry.cls = CLS_ZERO;
        end else if (i_pixel >= r_high) begin
            o_entry.cls = CLS_FULL;
        end else begin
            o_entry.cls = CLS_DIV;
        end
    end

    always_comb begin
        n_low      = r_low;
        n_high     = r_high;
        n_awaiting = r_awaiting;
        if (accept && !i_kind) begin
            n_awaiting = 1'b0;
            if (r_awaiting) begin
                n_low  = i_pixel;
                n_high = i_pixel;
            end else begin
                if (i_pixel > r_high) n_high = i_pixel;
                if (i_pixel < r_low)  n_low  = i_pixel;
            end
        end else if (accept && i_last) begin
            n_awaiting = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low      <= '0;
            r_high     <= '0;
            r_awaiting <= 1'b1;
        end else begin
            r_low      <= n_low;
            r_high     <= n_high;
            r_awaiting <= n_awaiting;
        end
    end

endmodule

`default_nettype wire

>>> src/ics_queue.sv
// ----------------------------------------------------------------------------
// ics_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ics_queue
    import ics_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output t_qstat      o_qstat
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/ics_back.sv
// ----------------------------------------------------------------------------
// ics_back
// Restoring divider for (p-min)*255/(max-min) and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ics_back
    import ics_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_entry           i_head,
    input  wire t_qstat           i_qstat,
    input  wire logic             i_stall,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_stretched,
    output logic                  o_final_res
);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

    t_state               r_state, n_state;
    logic [STEP_W-1:0]    r_cnt, n_cnt;
    logic [PIX_W-1:0]     r_rem, n_rem;
    logic [PIX_W-1:0]     r_lsb, n_lsb;
    logic [PIX_W-1:0]     r_span, n_span;
    logic [PIX_W-1:0]     r_q, n_q;
    logic                 r_last, n_last;
    logic                 r_out_valid, n_out_valid;
    logic [PIX_W-1:0]     r_stretched, n_stretched;
    logic                 r_final, n_final;

    logic                 out_free;
    logic [2*PIX_W-1:0]   dividend;
    logic [PIX_W:0]       trial;
    logic [PIX_W:0]       trial_sub;
    logic                 ge;
    logic [PIX_W-1:0]     rem_next;

    assign out_free    = !r_out_valid || !i_stall;
    assign o_valid     = r_out_valid;
    assign o_stretched = r_stretched;
    assign o_final_res = r_final;

    // x*255 = (x<<8) - x
    assign dividend  = {i_head.diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, i_head.diff};
    assign trial     = {r_rem, r_lsb[PIX_W-1]};
    assign trial_sub = trial - {1'b0, r_span};
    assign ge        = (trial >= {1'b0, r_span});
    assign rem_next  = ge ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_lsb       = r_lsb;
        n_span      = r_span;
        n_q         = r_q;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_stretched = r_stretched;
        n_final     = r_final;
        o_pop       = 1'b0;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty && out_free) begin
                    o_pop = 1'b1;
                    case (i_head.cls)
                        CLS_FULL: begin
                            n_out_valid = 1'b1;
                            n_stretched = '1;
                            n_final     = i_head.last;
                        end
                        CLS_DIV: begin
                            n_rem   = dividend[2*PIX_W-1:PIX_W];
                            n_lsb   = dividend[PIX_W-1:0];
                            n_span  = i_head.span;
                            n_last  = i_head.last;
                            n_q     = '0;
                            n_cnt   = '0;
                            n_state = ST_DIV;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_stretched = '0;
                            n_final     = i_head.last;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (r_cnt != STEP_W'(DIV_STEPS - 1)) begin
                    n_rem = rem_next;
                    n_lsb = {r_lsb[PIX_W-2:0], 1'b0};
                    n_q   = {r_q[PIX_W-2:0], ge};
                    n_cnt = r_cnt + 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_stretched = {r_q[PIX_W-2:0], ge};
                    n_final     = r_last;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_lsb       <= n_lsb;
        r_span      <= n_span;
        r_q         <= n_q;
        r_last      <= n_last;
        r_stretched <= n_stretched;
        r_final     <= n_final;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-pass min-max contrast stretch. A queue of
// pixel words (directed corner cases, then random images with measuring and
// normalizing passes, broken passes and noise) feeds a clocked driver. Each
// accepted word goes through a local model of the running min/max. Its
// results are kept in order and compared field by field by a clocked monitor.
// Both sides idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import ics_pkg::*;

    localparam bit KIND_MEASURE   = 1'b0;
    localparam bit KIND_NORMALIZE = 1'b1;
    localparam int RANDOM_WORDS   = 1700;
    localparam int CALM_TAIL      = 120;
    localparam int SETTLE_CYCLES  = 40;
    localparam int CYCLE_LIMIT    = 600000;

    typedef struct {
        bit             kind;
        bit [PIX_W-1:0] pixel;
        bit             last;
        bit             drain_first;
    } pix_word_t;

    typedef struct {
        bit [PIX_W-1:0] stretched;
        bit             final_res;
    } stretch_out_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_kind = 1'b0;
    logic [PIX_W-1:0] i_pixel = '0;
    logic             i_last = 1'b0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [PIX_W-1:0] o_stretched;
    logic             o_final_res;

    pix_word_t    pending_words[$];
    stretch_out_t due_outputs[$];

    bit [PIX_W-1:0] run_min = '0;
    bit [PIX_W-1:0] run_max = '0;
    bit             awaiting_first = 1'b1;

    int errors = 0;
    int words_sent = 0;
    int norm_sent = 0;
    int outputs_seen = 0;
    int images_closed = 0;
    int drain_pauses = 0;
    int send_gap = 0;
    int stall_left = 0;
    int cycle_count = 0;

    image_contrast_stretch DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_pixel     (i_pixel),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_stretched (o_stretched),
        .o_final_res (o_final_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit [PIX_W-1:0] stretch_level(bit [PIX_W-1:0] p,
                                                     bit [PIX_W-1:0] lo,
                                                     bit [PIX_W-1:0] hi);
        int unsigned q;
        if (hi <= lo) return '0;
        if (p <= lo) return '0;
        if (p >= hi) return 8'd255;
        q = ((int'(p) - int'(lo)) * 255) / (int'(hi) - int'(lo));
        if (q > 255) q = 255;
        return q[PIX_W-1:0];
    endfunction

    task automatic absorb_word(bit kind, bit [PIX_W-1:0] pixel, bit last);
        stretch_out_t res;
        if (kind == KIND_MEASURE) begin
            if (awaiting_first) begin
                run_min = pixel;
                run_max = pixel;
                awaiting_first = 1'b0;
            end else begin
                if (pixel > run_max) run_max = pixel;
                if (pixel < run_min) run_min = pixel;
            end
        end else begin
            res.stretched = stretch_level(pixel, run_min, run_max);
            res.final_res = last;
            due_outputs.push_back(res);
            norm_sent++;
            if (last) begin
                awaiting_first = 1'b1;
                images_closed++;
            end
        end
    endtask

    task automatic queue_word(bit kind, bit [PIX_W-1:0] pixel, bit last,
                              bit drain_first = 1'b0);
        pix_word_t w;
        w.kind = kind;
        w.pixel = pixel;
        w.last = last;
        w.drain_first = drain_first;
        pending_words.push_back(w);
    endtask

    // one image: measuring pass then normalizing pass, sometimes broken
    task automatic queue_random_image(bit drain_first);
        int n_meas;
        int n_norm;
        int lo_b;
        int hi_b;
        int k;
        bit [PIX_W-1:0] p;
        bit end_flag;
        n_meas = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
        n_norm = $urandom_range(1, 12);
        lo_b = $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0) begin
            lo_b = 0;
            hi_b = 255;
        end else begin
            hi_b = lo_b + $urandom_range(0, 60);
            if (hi_b > 255) hi_b = 255;
        end
        for (k = 0; k < n_meas; k++) begin
            p = PIX_W'($urandom_range(lo_b, hi_b));
            end_flag = (k == n_meas - 1) && ($urandom_range(0, 9) != 0);
            queue_word(KIND_MEASURE, p, end_flag, drain_first && (k == 0));
        end
        for (k = 0; k < n_norm; k++) begin
            if ($urandom_range(0, 4) == 0)
                p = PIX_W'($urandom_range(0, 255));
            else
                p = PIX_W'($urandom_range(lo_b, hi_b));
            if ($urandom_range(0, 9) == 0)
                queue_word(KIND_MEASURE, PIX_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
            end_flag = (k == n_norm - 1) && ($urandom_range(0, 11) != 0);
            queue_word(KIND_NORMALIZE, p, end_flag);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        pix_word_t w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_kind <= 1'b0;
            i_pixel <= '0;
            i_last <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                absorb_word(i_kind, i_pixel, i_last);
                words_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_words[0].drain_first && due_outputs.size() != 0) begin
                    i_valid <= 1'b0;
                end else if (pending_words.size() > CALM_TAIL &&
                             $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 18) - 1;
                    i_valid <= 1'b0;
                end else begin
                    w = pending_words.pop_front();
                    if (w.drain_first) drain_pauses++;
                    i_valid <= 1'b1;
                    i_kind <= w.kind;
                    i_pixel <= w.pixel;
                    i_last <= w.last;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        stretch_out_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (due_outputs.size() == 0) begin
                    $display("%0t: unexpected word stretched=%0d final_res=%0b",
                             $time, o_stretched, o_final_res);
                    errors++;
                end else begin
                    want = due_outputs.pop_front();
                    outputs_seen++;
                    if (o_stretched !== want.stretched) begin
                        $display("%0t: stretched expected %0d actual %0d",
                                 $time, want.stretched, o_stretched);
                        errors++;
                    end
                    if (o_final_res !== want.final_res) begin
                        $display("%0t: final_res expected %0b actual %0b",
                                 $time, want.final_res, o_final_res);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin
        int base;
        // normalizing right after reset: flat, all zero
        queue_word(KIND_NORMALIZE, 8'd0, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd255, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd128, 1'b1);
        // span 10..200, below, inside and above the range
        queue_word(KIND_MEASURE, 8'd10, 1'b0);
        queue_word(KIND_MEASURE, 8'd200, 1'b1);
        queue_word(KIND_NORMALIZE, 8'd0, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd105, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd255, 1'b1);
        // flat image
        queue_word(KIND_MEASURE, 8'd77, 1'b1);
        queue_word(KIND_NORMALIZE, 8'd77, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd0, 1'b1);
        // full range
        queue_word(KIND_MEASURE, 8'd255, 1'b0);
        queue_word(KIND_MEASURE, 8'd0, 1'b1);
        queue_word(KIND_NORMALIZE, 8'd1, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd127, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd128, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd254, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd255, 1'b1);
        // measuring word in the middle of a normalizing pass
        queue_word(KIND_MEASURE, 8'd50, 1'b0);
        queue_word(KIND_MEASURE, 8'd60, 1'b1);
        queue_word(KIND_NORMALIZE, 8'd55, 1'b0);
        queue_word(KIND_MEASURE, 8'd40, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd45, 1'b0);
        queue_word(KIND_NORMALIZE, 8'd60, 1'b1);
        base = pending_words.size();
        queue_random_image(1'b1);
        while (pending_words.size() < base + RANDOM_WORDS) begin
            if ($urandom_range(0, 9) == 0)
                queue_word(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)),
                           $urandom_range(0, 3) == 0);
            else
                queue_random_image($urandom_range(0, 15) == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid) @(negedge i_clk);
        while (due_outputs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (due_outputs.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, due_outputs.size());
            errors++;
        end
        $display("run: %0d pixel words sent, %0d normalized, %0d outputs checked",
                 words_sent, norm_sent, outputs_seen);
        $display("run: %0d images closed, %0d drain pauses, %0d mismatches",
                 images_closed, drain_pauses, errors);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
